// ===== rtl/core/afhw_pkg.sv =====
package afhw_pkg;

   localparam logic [12:0] HDR_LEN      = 13'd7;
   localparam logic [2:0]  SEEN_MAX     = 3'd7;
   localparam logic [2:0]  HDR_LAST_POS = 3'd6;
   localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE  = 4'hF;
   localparam logic [3:0]  RATE_IDX_MAX = 4'd12;
   localparam logic [2:0]  MPEG2_CODE   = 3'd2;
   localparam logic [2:0]  MPEG4_CODE   = 3'd4;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_SHORT = 3'd1,
      ST_NO_SYNC   = 3'd2,
      ST_BAD_LAYER = 3'd3,
      ST_BAD_RATE  = 3'd4,
      ST_BAD_CHAN  = 3'd5
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } in_beat_type;

   typedef struct packed {
      logic       valid;
      logic       id;
      logic       crc;
      logic [1:0] profile;
      logic [3:0] rate_idx;
      logic [2:0] chan_idx;
   } hdr_fields_type;

   // first member lands in the top bits of tdata
   typedef struct packed {
      logic        pad;
      logic [31:0] byte_total;
      logic [31:0] frame_total;
      logic [3:0]  channel_count;
      logic [16:0] sample_rate_hz;
      logic [2:0]  audio_profile;
      logic        has_crc;
      logic [2:0]  mpeg_version;
      status_type  status;
   } rsp_fields_type;

   function automatic logic [16:0] rate_hz(input logic [3:0] idx);
      logic [16:0] hz;
      unique case (idx)
         4'd0:    hz = 17'd96000;
         4'd1:    hz = 17'd88200;
         4'd2:    hz = 17'd64000;
         4'd3:    hz = 17'd48000;
         4'd4:    hz = 17'd44100;
         4'd5:    hz = 17'd32000;
         4'd6:    hz = 17'd24000;
         4'd7:    hz = 17'd22050;
         4'd8:    hz = 17'd16000;
         4'd9:    hz = 17'd12000;
         4'd10:   hz = 17'd11025;
         4'd11:   hz = 17'd8000;
         4'd12:   hz = 17'd7350;
         default: hz = 17'd0;
      endcase
      return hz;
   endfunction

   function automatic logic [3:0] chan_count(input logic [2:0] idx);
      return (idx == 3'd7) ? 4'd8 : {1'b0, idx};
   endfunction

endpackage

// ===== rtl/core/afhw_in_reg.sv =====
module afhw_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  take,
   output afhw_pkg::in_beat_type beat
);
   import afhw_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign beat = '{valid: valid_ff, data: data_ff, last: last_ff};

endmodule

// ===== rtl/core/afhw_walker.sv =====
module afhw_walker #(
   parameter int TOTAL_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  afhw_pkg::in_beat_type    beat,
   input  logic                     fire,
   output logic                     res_valid,
   output afhw_pkg::rsp_fields_type res_data
);
   import afhw_pkg::*;

   typedef enum logic [1:0] {
      PH_CAPTURE = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   localparam int TW = TOTAL_WIDTH;

   phase_type      phase_ff, phase_in;
   logic [7:0]     hdr_ff [6];
   logic [2:0]     pos_ff, pos_in;
   logic [12:0]    remain_ff, remain_in;
   logic [2:0]     blocks_ff, blocks_in;
   logic [12:0]    len_ff, len_in;
   logic [2:0]     seen_ff, seen_in;
   hdr_fields_type lat_ff, lat_in;
   status_type     err_ff, err_in;
   logic [TW-1:0]  frames_ff, frames_in;
   logic [TW-1:0]  bytes_ff, bytes_in;

   logic [12:0]    hdr_len;
   logic [3:0]     rate_idx;
   logic           done_frame;
   logic [2:0]     add_blocks;
   logic [12:0]    add_len;
   logic [TW:0]    frames_sum, bytes_sum;
   status_type     status;
   logic           show_hdr;
   logic [31:0]    frames_out, bytes_out;

   assign hdr_len  = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};
   assign rate_idx = hdr_ff[2][5:2];

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      remain_in  = remain_ff;
      blocks_in  = blocks_ff;
      len_in     = len_ff;
      seen_in    = seen_ff;
      lat_in     = lat_ff;
      err_in     = err_ff;
      done_frame = 1'b0;
      add_blocks = blocks_ff;
      add_len    = len_ff;
      if (fire) begin
         seen_in = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 3'd1;
         unique case (phase_ff)
            PH_CAPTURE: begin
               if (pos_ff == HDR_LAST_POS) begin
                  pos_in = 3'd0;
                  priority if (hdr_ff[0] != SYNC_BYTE || hdr_ff[1][7:4] != SYNC_NIBBLE) begin
                     err_in   = ST_NO_SYNC;
                     phase_in = PH_DONE;
                  end else if (hdr_ff[1][2:1] != 2'd0) begin
                     err_in   = ST_BAD_LAYER;
                     phase_in = PH_DONE;
                  end else if (rate_idx > RATE_IDX_MAX) begin
                     err_in   = ST_BAD_RATE;
                     phase_in = PH_DONE;
                  end else begin
                     lat_in = '{valid: 1'b1, id: hdr_ff[1][3], crc: ~hdr_ff[1][0],
                                profile: hdr_ff[2][7:6], rate_idx: rate_idx,
                                chan_idx: {hdr_ff[2][0], hdr_ff[3][7:6]}};
                     if (hdr_len < HDR_LEN) begin
                        phase_in = PH_DONE;
                     end else begin
                        blocks_in  = {1'b0, beat.data[1:0]} + 3'd1;
                        len_in     = hdr_len;
                        remain_in  = hdr_len - HDR_LEN;
                        add_blocks = blocks_in;
                        add_len    = hdr_len;
                        if (remain_in == 13'd0) begin
                           done_frame = 1'b1;
                           phase_in   = PH_CAPTURE;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_ff - 13'd1;
               if (remain_in == 13'd0) begin
                  done_frame = 1'b1;
                  phase_in   = PH_CAPTURE;
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // saturating totals
   assign frames_sum = {1'b0, frames_ff} + (TW + 1)'(add_blocks);
   assign bytes_sum  = {1'b0, bytes_ff} + (TW + 1)'(add_len);

   always_comb begin
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      if (done_frame) begin
         frames_in = frames_sum[TW] ? {TW{1'b1}} : frames_sum[TW-1:0];
         bytes_in  = bytes_sum[TW] ? {TW{1'b1}} : bytes_sum[TW-1:0];
      end
   end

   generate
      if (TW >= 32) begin : g_wide
         assign frames_out = frames_in[31:0];
         assign bytes_out  = bytes_in[31:0];
      end else begin : g_narrow
         assign frames_out = 32'(frames_in);
         assign bytes_out  = 32'(bytes_in);
      end
   endgenerate

   always_comb begin
      priority if (err_in != ST_OK) begin
         status = err_in;
      end else if (seen_in != SEEN_MAX) begin
         status = ST_TOO_SHORT;
      end else begin
         status = ST_OK;
      end
   end

   assign show_hdr  = lat_in.valid && status != ST_TOO_SHORT;
   assign res_valid = fire && beat.last;

   always_comb begin
      res_data                = '0;
      res_data.status         = status;
      if (show_hdr) begin
         res_data.mpeg_version   = lat_in.id ? MPEG2_CODE : MPEG4_CODE;
         res_data.has_crc        = lat_in.crc;
         res_data.audio_profile  = {1'b0, lat_in.profile} + 3'd1;
         res_data.sample_rate_hz = rate_hz(lat_in.rate_idx);
         res_data.channel_count  = chan_count(lat_in.chan_idx);
      end
      if (status != ST_TOO_SHORT) begin
         res_data.frame_total = frames_out;
         res_data.byte_total  = bytes_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && beat.last)) begin
         phase_ff  <= PH_CAPTURE;
         pos_ff    <= '0;
         remain_ff <= '0;
         blocks_ff <= '0;
         len_ff    <= '0;
         seen_ff   <= '0;
         lat_ff    <= '0;
         err_ff    <= ST_OK;
         frames_ff <= '0;
         bytes_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         remain_ff <= remain_in;
         blocks_ff <= blocks_in;
         len_ff    <= len_in;
         seen_ff   <= seen_in;
         lat_ff    <= lat_in;
         err_ff    <= err_in;
         frames_ff <= frames_in;
         bytes_ff  <= bytes_in;
      end
   end

   // header store: the seventh byte is used straight from the input register
   always_ff @(posedge clock) begin
      if (fire && phase_ff == PH_CAPTURE && pos_ff != HDR_LAST_POS) begin
         hdr_ff[pos_ff] <= beat.data;
      end
   end

endmodule

// ===== rtl/core/afhw_out_reg.sv =====
module afhw_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     res_valid,
   input  afhw_pkg::rsp_fields_type res_data,
   output logic                     take,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [95:0]              rsp_tdata
);
   import afhw_pkg::*;

   logic           valid_ff, valid_in;
   rsp_fields_type data_ff;

   assign take     = !valid_ff || rsp_tready;
   assign valid_in = take ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= res_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/core/adts_frame_header_walker_top.sv =====
// ADTS frame header walker.
// req channel: one buffer byte per beat, tlast on the final byte of the buffer.
// The buffer must start at a frame header. Each 7-byte header is checked,
// its payload skipped, and complete frames are added to the totals.
// rsp channel: exactly one summary beat per buffer, sent for the tlast byte:
// status, fields of the last good header, frame and byte totals.
// The tlast beat passes the input register, then the result register, before
// rsp_tvalid rises. Throughput: one byte per cycle, set by the combinational
// header/counter update between the two registers, while the result register
// has room; a tlast byte waits in the input register while it is full.
// Totals saturate at TOTAL_WIDTH bits and are reported in 32 bits.
// Reset clears the walk state and both registers; after each summary the
// walker returns to that same state for the next buffer.
// When rsp_tready is low the summary holds in the result register; bytes keep
// flowing until a second summary would need the register, then req_tready drops.
module adts_frame_header_walker_top #(
   parameter int TOTAL_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [5:3] mpeg_version, [6] has_crc, [9:7] audio_profile,
   // [26:10] sample_rate_hz, [30:27] channel_count, [62:31] frame_total,
   // [94:63] byte_total, [95] zero
   output logic [95:0] rsp_tdata
);
   import afhw_pkg::*;

   in_beat_type    beat;
   logic           take;
   logic           advance;
   logic           res_valid;
   rsp_fields_type res_data;
   rsp_fields_type rsp_view;

   // only the tlast byte needs room in the result register
   assign advance = take || !beat.last;

   afhw_in_reg u_in (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .take(advance), .beat(beat)
   );

   afhw_walker #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_walk (
      .clock(clock), .reset(reset),
      .beat(beat), .fire(beat.valid && advance),
      .res_valid(res_valid), .res_data(res_data)
   );

   afhw_out_reg u_out (
      .clock(clock), .reset(reset),
      .res_valid(res_valid), .res_data(res_data), .take(take),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   assign rsp_view = rsp_fields_type'(rsp_tdata);

   // channel index covers all codes, so no bad-channel status
   a_no_bad_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_view.status != ST_BAD_CHAN)
      else $error("bad channel status reported");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.status == ST_TOO_SHORT |->
         rsp_view.frame_total == 32'd0 && rsp_view.byte_total == 32'd0 &&
         rsp_view.mpeg_version == 3'd0)
      else $error("short buffer summary not cleared");

   a_hdr_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.audio_profile != 3'd0 |->
         rsp_view.mpeg_version == MPEG2_CODE || rsp_view.mpeg_version == MPEG4_CODE)
      else $error("header fields inconsistent");

   a_one_summary: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> ##1 rsp_tvalid)
      else $error("summary missing after last byte");

endmodule
